// ----- rtl/core/u8v_pkg.sv -----
// shared types, constants and helpers of the utf-8 text validator
package u8v_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int PEND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NON_NORMAL = 2'd1,
    ST_MALFORMED  = 2'd2,
    ST_NEWLINE    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLOW_NON_NORMAL = 2'd0,
    REG_ALLOW_NEW_LINE   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic allow_non_normal;
    logic allow_new_line;
  } cfg_t;

  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic              cr;
    status_t           fe;
  } chk_state_t;

  localparam logic [BYTE_W-1:0] MASK_C0 = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] MASK_E0 = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] MASK_F0 = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] MASK_F8 = 8'b1111_1000;
  localparam logic [BYTE_W-1:0] PAT_CONT = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] PAT_LEAD2 = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] PAT_LEAD3 = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] PAT_LEAD4 = 8'b1111_0000;

  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_US   = 8'h1F;
  localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_UNDS = 8'h5F;

  function automatic logic is_plain(input logic [BYTE_W-1:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDS || b == CH_DASH;
  endfunction

endpackage

// ----- rtl/core/u8v_in_if.sv -----
// input channel: one text byte and its end-of-text flag
interface u8v_in_if;
  import u8v_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/u8v_out_if.sv -----
// result channel: running status and end-of-text flag
interface u8v_out_if;
  import u8v_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                text_done;

  modport source (output valid, output status, output text_done, input ready);
  modport sink (input valid, input status, input text_done, output ready);
endinterface

// ----- rtl/core/u8v_cfg_if.sv -----
// configuration write channel
interface u8v_cfg_if;
  import u8v_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/u8v_cfg_regs.sv -----
// configuration registers of the utf-8 text validator
module u8v_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  u8v_cfg_if.sink       cfg_if,
  output u8v_pkg::cfg_t cfg
);
  import u8v_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_ALLOW_NON_NORMAL: cfg_nxt.allow_non_normal = cfg_if.data[0];
        REG_ALLOW_NEW_LINE:   cfg_nxt.allow_new_line   = cfg_if.data[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ----- rtl/core/u8v_byte_check.sv -----
// per-byte utf-8 and character class check with sticky text state
module u8v_byte_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [u8v_pkg::BYTE_W-1:0] text_byte,
  input  logic                       last_byte,
  input  u8v_pkg::cfg_t              cfg,
  output u8v_pkg::status_t           status,
  output u8v_pkg::chk_state_t        chk_st
);
  import u8v_pkg::*;

  chk_state_t st_r;
  chk_state_t st_nxt;

  status_t           err;
  logic [PEND_W-1:0] pend_b;
  logic              cr_b;
  logic [PEND_W-1:0] pend_c;
  logic              cr_c;
  status_t           fe_c;
  status_t           status_c;

  // single byte check against the stored sequence state
  always_comb begin
    err    = ST_OK;
    pend_b = st_r.pend;
    cr_b   = st_r.cr;
    if (text_byte[BYTE_W-1]) begin
      if (!cfg.allow_non_normal) begin
        err = ST_NON_NORMAL;
      end else if (st_r.pend == '0) begin
        priority if (st_r.cr) begin
          err = ST_MALFORMED;
        end else if ((text_byte & MASK_C0) == PAT_CONT) begin
          err = ST_MALFORMED;
        end else if ((text_byte & MASK_E0) == PAT_LEAD2) begin
          pend_b = PEND_W'(1);
        end else if ((text_byte & MASK_F0) == PAT_LEAD3) begin
          pend_b = PEND_W'(2);
        end else if ((text_byte & MASK_F8) == PAT_LEAD4) begin
          pend_b = PEND_W'(3);
        end else begin
          err = ST_MALFORMED;
        end
      end else if ((text_byte & MASK_C0) != PAT_CONT) begin
        err = ST_MALFORMED;
      end else begin
        pend_b = st_r.pend - PEND_W'(1);
      end
    end else begin
      priority if (st_r.pend != '0) begin
        err = ST_MALFORMED;
      end else if (!cfg.allow_non_normal && !is_plain(text_byte)) begin
        err = ST_NON_NORMAL;
      end else if (!cfg.allow_new_line && (text_byte == CH_LF || text_byte == CH_CR)) begin
        err = ST_NEWLINE;
      end else if (text_byte <= CH_US && text_byte != CH_LF && text_byte != CH_CR &&
                   text_byte != CH_TAB) begin
        err = ST_MALFORMED;
      end else if (text_byte == CH_DEL) begin
        err = ST_MALFORMED;
      end else if (st_r.cr) begin
        if (text_byte != CH_LF) begin
          err = ST_MALFORMED;
        end else begin
          cr_b = 1'b0;
        end
      end else if (text_byte == CH_CR) begin
        cr_b = 1'b1;
      end
    end
  end

  // first error sticks, unfinished text at the end is malformed
  always_comb begin
    pend_c = st_r.pend;
    cr_c   = st_r.cr;
    fe_c   = st_r.fe;
    if (st_r.fe == ST_OK) begin
      fe_c = err;
      if (err == ST_OK) begin
        pend_c = pend_b;
        cr_c   = cr_b;
      end
    end
    status_c = fe_c;
    if (last_byte && fe_c == ST_OK && (pend_c != '0 || cr_c)) begin
      status_c = ST_MALFORMED;
    end
    if (last_byte) begin
      st_nxt = '{pend: '0, cr: 1'b0, fe: ST_OK};
    end else begin
      st_nxt = '{pend: pend_c, cr: cr_c, fe: status_c};
    end
  end

  assign status = status_c;
  assign chk_st = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pend: '0, cr: 1'b0, fe: ST_OK};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end
endmodule

// ----- rtl/core/utf8_text_validator_unit.sv -----
// top level of the utf-8 text validator
// usage:
//   in_if carries one text byte per item with last_byte marking the end of a text.
//   out_if returns exactly one item per input byte: status is the first error
//   of the text so far (0 ok, 1 non-normal, 2 malformed, 3 newline) and
//   text_done repeats last_byte, so status is final when text_done is 1.
//   cfg_if writes allow_non_normal (index 0) and allow_new_line (index 1);
//   other indexes are ignored. write only while no item is in flight.
// timing:
//   an accepted byte is held in the input register and its result is written to the
//   output register when the byte leaves it, which waits while a held result is not taken.
//   throughput is one byte per cycle while results are taken; the byte check is
//   one pass of logic over the input register and the small per-text state.
// reset (synchronous, active low) clears the valid flags of both registers, the text
// state and the configuration. when out_if.ready is low the result holds, one more byte
// is taken into the input register, then in_if.ready drops until the result
// is taken.
module utf8_text_validator_unit (
  input  logic    clk,
  input  logic    rst_n,
  u8v_cfg_if.sink cfg_if,
  u8v_in_if.sink  in_if,
  u8v_out_if.source out_if
);
  import u8v_pkg::*;

  logic              stage_vld_r;
  logic [BYTE_W-1:0] stage_byte_r;
  logic              stage_last_r;
  logic              out_vld_r;
  status_t           out_status_r;
  logic              out_done_r;
  logic              adv;
  logic              in_take;
  cfg_t              cfg;
  status_t           chk_status;
  chk_state_t        chk_st;

  u8v_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  u8v_byte_check u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .text_byte (stage_byte_r),
    .last_byte (stage_last_r),
    .cfg       (cfg),
    .status    (chk_status),
    .chk_st    (chk_st)
  );

  assign adv          = stage_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !stage_vld_r || adv;
  assign in_take      = in_if.valid && in_if.ready;
  assign out_if.valid = out_vld_r;
  assign out_if.status = out_status_r;
  assign out_if.text_done = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (in_take) begin
        stage_vld_r <= 1'b1;
      end else if (adv) begin
        stage_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_if.text_byte;
      stage_last_r <= in_if.last_byte;
    end
    if (adv) begin
      out_status_r <= chk_status;
      out_done_r   <= stage_last_r;
    end
  end

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_vld_r && out_vld_r && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while both registers are full");

  a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage_last_r) |=> (chk_st.pend == '0 && !chk_st.cr && chk_st.fe == ST_OK))
    else $error("text state not cleared after last byte");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv))
    else $error("result appeared without a byte leaving the input register");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !stage_last_r && chk_st.fe != ST_OK) |=> (chk_st.fe == $past(chk_st.fe)))
    else $error("first error changed within a text");
`endif
endmodule

// ----- sim/tb_utf8_text_validator_unit.sv -----
// self-checking testbench for the utf-8 text validator: directed and random texts against a status predictor
module tb_utf8_text_validator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import u8v_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int PHASES = 8;
  localparam int BYTES_PER_PHASE = 215;
  localparam int MAX_PRINTS = 20;

  typedef struct packed {
    status_t status;
    logic    done;
  } status_item_t;

  typedef enum {
    K_PLAIN, K_PUNCT, K_TAB, K_CRLF, K_MULTI, K_BROKEN, K_NOISE
  } char_kind_t;

  class text_status_predictor;
    logic              allow_nn;
    logic              allow_nl;
    logic [PEND_W-1:0] pend;
    logic              cr_wait;
    status_t           err;
    status_item_t      status_q[$];
    int                fails;
    int                final_cnt[4];

    function new();
      allow_nn = 1'b0;
      allow_nl = 1'b0;
      pend     = '0;
      cr_wait  = 1'b0;
      err      = ST_OK;
      fails    = 0;
      foreach (final_cnt[i]) final_cnt[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
      if (idx == REG_ALLOW_NON_NORMAL) allow_nn = d[0];
      else if (idx == REG_ALLOW_NEW_LINE) allow_nl = d[0];
    endfunction

    function status_t judge_byte(logic [BYTE_W-1:0] b);
      if (b[7]) begin
        if (!allow_nn) return ST_NON_NORMAL;
        if (pend == 0) begin
          if (cr_wait) return ST_MALFORMED;
          if ((b & MASK_C0) == PAT_CONT) return ST_MALFORMED;
          if ((b & MASK_E0) == PAT_LEAD2) pend = 2'd1;
          else if ((b & MASK_F0) == PAT_LEAD3) pend = 2'd2;
          else if ((b & MASK_F8) == PAT_LEAD4) pend = 2'd3;
          else return ST_MALFORMED;
        end else begin
          if ((b & MASK_C0) != PAT_CONT) return ST_MALFORMED;
          pend = pend - 2'd1;
        end
        return ST_OK;
      end
      if (pend != 0) return ST_MALFORMED;
      if (!allow_nn && !(b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                   CH_UNDS, CH_DASH}))
        return ST_NON_NORMAL;
      if (!allow_nl && (b == CH_LF || b == CH_CR)) return ST_NEWLINE;
      if (b <= CH_US && b != CH_LF && b != CH_CR && b != CH_TAB) return ST_MALFORMED;
      if (b == CH_DEL) return ST_MALFORMED;
      if (cr_wait) begin
        if (b != CH_LF) return ST_MALFORMED;
        cr_wait = 1'b0;
      end else if (b == CH_CR) begin
        cr_wait = 1'b1;
      end
      return ST_OK;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      status_item_t it;
      if (err == ST_OK) err = judge_byte(b);
      if (last && err == ST_OK && (pend != 0 || cr_wait)) err = ST_MALFORMED;
      it.status = err;
      it.done   = last;
      status_q.push_back(it);
      if (last) begin
        final_cnt[err]++;
        pend    = '0;
        cr_wait = 1'b0;
        err     = ST_OK;
      end
    endfunction

    function void check_status(logic [STATUS_W-1:0] st, logic done);
      status_item_t exp_it;
      if (status_q.size() == 0) begin
        fails++;
        if (fails <= MAX_PRINTS)
          $display("[%0t] unexpected result: status %0d text_done %0b", $time, st, done);
        return;
      end
      exp_it = status_q.pop_front();
      if (st !== exp_it.status) begin
        fails++;
        if (fails <= MAX_PRINTS)
          $display("[%0t] status mismatch: expected %0d actual %0d", $time,
                   exp_it.status, st);
      end
      if (done !== exp_it.done) begin
        fails++;
        if (fails <= MAX_PRINTS)
          $display("[%0t] text_done mismatch: expected %0b actual %0b", $time,
                   exp_it.done, done);
      end
    endfunction

    function void wrap_up();
      if (status_q.size() != 0) begin
        $display("[%0t] %0d results never arrived", $time, status_q.size());
        fails += status_q.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  u8v_cfg_if cfg_if ();
  u8v_in_if  in_if ();
  u8v_out_if out_if ();

  utf8_text_validator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  text_status_predictor pred = new();

  logic [BYTE_W-1:0] text_q[$];
  int in_gap_pct;
  int out_gap_pct;
  int out_stall_left;
  int bytes_sent;
  int texts_sent;
  int settings_used;

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) pred.check_status(out_if.status, out_if.text_done);
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      out_if.ready   <= 1'b0;
    end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
      out_stall_left <= $urandom_range(0, 5);
      out_if.ready   <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      in_if.valid     <= 1'b1;
      in_if.text_byte <= text_q[i];
      in_if.last_byte <= (i == text_q.size() - 1);
      do @(posedge clk); while (!in_if.ready);
      pred.note_byte(text_q[i], i == text_q.size() - 1);
      bytes_sent++;
      if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    texts_sent++;
    text_q.delete();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pred.status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    pred.set_reg(idx, d);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic nn, logic nl);
    drain();
    write_reg(REG_ALLOW_NON_NORMAL, nn);
    write_reg(REG_ALLOW_NEW_LINE, nl);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom_range(0, 1)));
    else write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom_range(0, 1)));
    settings_used++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 10) return BYTE_W'(8'h30 + r);
    if (r < 36) return BYTE_W'(8'h41 + (r - 10));
    if (r < 62) return BYTE_W'(8'h61 + (r - 36));
    return (r == 62) ? CH_UNDS : CH_DASH;
  endfunction

  function automatic char_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (!pred.allow_nn) begin
      if (r < 85) return K_PLAIN;
      if (r < 89) return K_CRLF;
      if (r < 93) return K_MULTI;
      if (r < 97) return K_PUNCT;
      return K_NOISE;
    end
    if (r < 35) return K_PLAIN;
    if (r < 53) return K_PUNCT;
    if (r < 60) return K_TAB;
    if (r < 70) return K_CRLF;
    if (r < 90) return K_MULTI;
    if (r < 95) return K_BROKEN;
    return K_NOISE;
  endfunction

  function automatic void add_char(char_kind_t kind);
    int n;
    case (kind)
      K_PLAIN: text_q.push_back(plain_char());
      K_PUNCT: text_q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
      K_TAB:   text_q.push_back(CH_TAB);
      K_CRLF: begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end
      K_MULTI: begin
        n = $urandom_range(1, 3);
        case (n)
          1: text_q.push_back(PAT_LEAD2 | BYTE_W'($urandom & 8'h1F));
          2: text_q.push_back(PAT_LEAD3 | BYTE_W'($urandom & 8'h0F));
          default: text_q.push_back(PAT_LEAD4 | BYTE_W'($urandom & 8'h07));
        endcase
        repeat (n) text_q.push_back(PAT_CONT | BYTE_W'($urandom & 8'h3F));
      end
      K_BROKEN: begin
        n = $urandom_range(0, 3);
        case (n)
          0: text_q.push_back(CH_CR);
          1: text_q.push_back(PAT_LEAD3 | BYTE_W'($urandom & 8'h0F));
          2: text_q.push_back(PAT_CONT | BYTE_W'($urandom & 8'h3F));
          default: text_q.push_back(MASK_F8 | BYTE_W'($urandom & 8'h07));
        endcase
      end
      default: text_q.push_back(BYTE_W'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    int target;
    int pct_pick;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    in_if.valid    = 1'b0;
    in_if.text_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready   = 1'b0;
    out_stall_left = 0;
    in_gap_pct     = 20;
    out_gap_pct    = 20;
    bytes_sent     = 0;
    texts_sent     = 0;
    settings_used  = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset mode first (only letters, digits, '_' and '-'), then the other modes
    text_q = '{8'h30, 8'h5A, 8'h61, CH_UNDS, CH_DASH};
    send_text();
    text_q = '{8'h20};
    send_text();
    text_q = '{8'hFF};
    send_text();
    set_mode(1'b1, 1'b0);
    text_q = '{CH_LF};
    send_text();
    set_mode(1'b1, 1'b1);
    text_q = '{8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    text_q = '{8'h80};
    send_text();
    text_q = '{8'hF8};
    send_text();
    text_q = '{CH_CR, CH_LF, CH_TAB};
    send_text();
    text_q = '{CH_CR, 8'h41};
    send_text();
    text_q = '{8'h00};
    send_text();
    text_q = '{CH_DEL, 8'h61};
    send_text();
    text_q = '{8'hC3};
    send_text();
    text_q = '{CH_CR};
    send_text();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) set_mode(ph[1], ph[0]);
      else set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      pct_pick = $urandom_range(0, 2);
      in_gap_pct  = (ph == PHASES - 1) ? 0 : (pct_pick == 0) ? 0 : (pct_pick == 1) ? 10 : 35;
      pct_pick = $urandom_range(0, 2);
      out_gap_pct = (ph == PHASES - 1) ? 0 : (pct_pick == 0) ? 0 : (pct_pick == 1) ? 10 : 35;
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        repeat ($urandom_range(1, $urandom_range(0, 3) == 0 ? 12 : 5))
          add_char(pick_kind());
        send_text();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    pred.wrap_up();
    $display("run: %0d bytes in %0d texts over %0d register settings", bytes_sent,
             texts_sent, settings_used);
    $display("run: final status ok %0d, non-normal %0d, malformed %0d, newline %0d",
             pred.final_cnt[ST_OK], pred.final_cnt[ST_NON_NORMAL],
             pred.final_cnt[ST_MALFORMED], pred.final_cnt[ST_NEWLINE]);
    if (pred.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
